>>> src/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg: shared types and codes for the reentrant lock table
// Status codes, request codes, field widths and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rlt_pkg;

  // Fixed channel field widths
  localparam int KEY_W    = 32;
  localparam int OWNER_W  = 8;
  localparam int DEPTH_W  = 16;
  localparam int IDX_W    = 3;
  localparam int STATUS_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  // Result status codes
  localparam status_t ST_GRANTED   = 3'd0;
  localparam status_t ST_BUSY      = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_RELEASED  = 3'd3;
  localparam status_t ST_UNMATCHED = 3'd4;
  localparam status_t ST_NOT_OWNER = 3'd5;
  localparam status_t ST_IGNORED   = 3'd6;
  localparam status_t ST_OVERFLOW  = 3'd7;

  // Request codes
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_in;  // capture the request beat
    logic lookup;   // register the key match and free-slot search
    logic commit;   // update the slot and load the result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_full; // result register holds a beat not yet taken
  } dp_stat_t;

endpackage

>>> src/rlt_in_if.sv
// ----------------------------------------------------------------------------
// rlt_in_if: request channel
// Valid/ready channel carrying one lock request per beat.
// ----------------------------------------------------------------------------
interface rlt_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] resource_key;
  logic [7:0]  requester_id;

  modport source (output valid, output cmd, output resource_key, output requester_id,
                  input ready);
  modport sink (input valid, input cmd, input resource_key, input requester_id,
                output ready);
endinterface

>>> src/rlt_out_if.sv
// ----------------------------------------------------------------------------
// rlt_out_if: result channel
// Valid/ready channel carrying one lock result per beat.
// ----------------------------------------------------------------------------
interface rlt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  slot_index;
  logic [15:0] depth_after;

  modport source (output valid, output status, output slot_index, output depth_after,
                  input ready);
  modport sink (input valid, input status, input slot_index, input depth_after,
                output ready);
endinterface

>>> src/rlt_ctrl.sv
// ----------------------------------------------------------------------------
// rlt_ctrl: request sequencer
// One-hot state machine stepping each request through capture, lookup and
// commit; holds the commit while the result register is still occupied.
// ----------------------------------------------------------------------------
module rlt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  rlt_pkg::dp_stat_t stat,
  output rlt_pkg::ctl_cmd_t ctl
);
  import rlt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   commit_ok;

  // Commit only when the result register is free or being drained
  assign commit_ok = !stat.out_full || out_ready;

  assign in_ready    = (state_r == S_IDLE);
  assign ctl.load_in = in_valid && (state_r == S_IDLE);
  assign ctl.lookup  = (state_r == S_LOOKUP);
  assign ctl.commit  = (state_r == S_UPDATE) && commit_ok;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (commit_ok) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/rlt_dpath.sv
// ----------------------------------------------------------------------------
// rlt_dpath: lock slot storage and request datapath
// Holds the slot table, runs the parallel key match and free-slot search,
// decides the result and updates at most one slot per request.
// ----------------------------------------------------------------------------
module rlt_dpath #(
  parameter int NUM_SLOTS  = 8,
  parameter int KEY_BITS   = 32,
  parameter int OWNER_BITS = 8,
  parameter int DEPTH_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rlt_pkg::ctl_cmd_t         ctl,
  output rlt_pkg::dp_stat_t         stat,
  input  logic                      in_cmd,
  input  logic [rlt_pkg::KEY_W-1:0]   in_resource_key,
  input  logic [rlt_pkg::OWNER_W-1:0] in_requester_id,
  input  logic                      out_ready,
  output logic                      out_valid,
  output rlt_pkg::status_t          out_status,
  output logic [rlt_pkg::IDX_W-1:0]   out_slot_index,
  output logic [rlt_pkg::DEPTH_W-1:0] out_depth_after
);
  import rlt_pkg::*;

  // Effective widths: the channel fields bound the key and owner
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int OW = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;
  localparam int DW = DEPTH_BITS;
  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [DW-1:0] DMAX = {DW{1'b1}};

  // Slot table
  logic [NUM_SLOTS-1:0] slot_valid_r;
  logic [KW-1:0]        slot_key_r   [NUM_SLOTS];
  logic [OW-1:0]        slot_owner_r [NUM_SLOTS];
  logic [DW-1:0]        slot_depth_r [NUM_SLOTS];

  // Captured request
  logic          cmd_r;
  logic [KW-1:0] key_r;
  logic [OW-1:0] who_r;

  // Lookup results
  logic          hit_c, free_c;
  logic [IW-1:0] hit_idx_c, free_idx_c;
  logic          hit_r, found_r;
  logic [IW-1:0] sel_r;

  // Decision
  logic [DW-1:0] cur_depth;
  logic [OW-1:0] cur_owner;
  status_t       status_c;
  logic [IW-1:0] idx_c;
  logic [DW-1:0] depth_c;
  logic          wr_en;
  logic [OW-1:0] wr_owner;
  logic [DW-1:0] wr_depth;
  logic [7:0]    idx_ext;
  logic [31:0]   depth_ext;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic [IDX_W-1:0]    out_slot_index_r;
  logic [DEPTH_W-1:0]  out_depth_after_r;

  // Request capture
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= in_cmd;
      key_r <= in_resource_key[KW-1:0];
      who_r <= in_requester_id[OW-1:0];
    end
  end

  // Parallel key match and lowest free slot; descending so the lowest wins
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid_r[i] && (slot_key_r[i] == key_r)) begin
        hit_c     = 1'b1;
        hit_idx_c = IW'(i);
      end
      if (!slot_valid_r[i]) begin
        free_c     = 1'b1;
        free_idx_c = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      hit_r   <= hit_c;
      found_r <= hit_c || free_c;
      sel_r   <= hit_c ? hit_idx_c : free_idx_c;
    end
  end

  // A freshly claimed slot starts unowned at depth zero
  assign cur_depth = hit_r ? slot_depth_r[sel_r] : '0;
  assign cur_owner = hit_r ? slot_owner_r[sel_r] : '0;

  // Result decision and slot update values
  always_comb begin
    status_c = ST_IGNORED;
    idx_c    = sel_r;
    depth_c  = cur_depth;
    wr_en    = 1'b0;
    wr_owner = cur_owner;
    wr_depth = cur_depth;
    if (key_r == '0) begin
      // empty path: no state change
      status_c = ST_IGNORED;
      idx_c    = '0;
      depth_c  = '0;
    end else if (cmd_r == CMD_ACQUIRE) begin
      if (!found_r) begin
        status_c = ST_FULL;
        idx_c    = '0;
        depth_c  = '0;
      end else begin
        wr_en = 1'b1;  // claims the slot even if the grant fails
        if ((cur_depth != '0) && (cur_owner != who_r)) begin
          status_c = ST_BUSY;
        end else if (cur_depth == DMAX) begin
          status_c = ST_OVERFLOW;
        end else begin
          status_c = ST_GRANTED;
          wr_owner = (cur_depth == '0) ? who_r : cur_owner;
          wr_depth = cur_depth + 1'b1;
          depth_c  = cur_depth + 1'b1;
        end
      end
    end else begin
      if (!hit_r || (cur_depth == '0)) begin
        status_c = ST_UNMATCHED;
        idx_c    = hit_r ? sel_r : '0;
        depth_c  = '0;
      end else if (cur_owner != who_r) begin
        status_c = ST_NOT_OWNER;
      end else begin
        status_c = ST_RELEASED;
        wr_en    = 1'b1;
        wr_depth = cur_depth - 1'b1;
        depth_c  = cur_depth - 1'b1;
      end
    end
  end

  assign idx_ext   = 8'(idx_c);
  assign depth_ext = 32'(depth_c);

  // Slot valid marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (ctl.commit && wr_en) begin
      slot_valid_r[sel_r] <= 1'b1;
    end
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (ctl.commit && wr_en) begin
      slot_key_r[sel_r]   <= key_r;
      slot_owner_r[sel_r] <= wr_owner;
      slot_depth_r[sel_r] <= wr_depth;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_status_r      <= status_c;
      out_slot_index_r  <= idx_ext[IDX_W-1:0];
      out_depth_after_r <= depth_ext[DEPTH_W-1:0];
    end
  end

  assign stat.out_full   = out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_slot_index_r;
  assign out_depth_after = out_depth_after_r;

endmodule

>>> src/reentrant_lock_table_unit.sv
// ----------------------------------------------------------------------------
// reentrant_lock_table_unit: table of reentrant locks keyed by resource id
// Top level joining the request sequencer and the slot datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests (cmd: acquire or release, resource_key,
//   requester_id); out_ch returns one result beat per request (status,
//   slot_index, depth_after). Both are valid/ready; a beat moves on a rising
//   edge with valid and ready high.
//   Each request passes through three steps: capture, a parallel match of the key
//   against all slots with a lowest-free-slot search, then the slot update
//   that also loads the result register. The result is valid once the
//   update step has committed; the next request is taken only after that
//   commit, paced by the single-request sequencer.
//   A busy lock is not queued: busy is returned and the requester retries.
//   Key zero is ignored. Claimed slots are never freed.
//   Reset (rst_n low, synchronous) empties the table and drops any pending
//   result. When out_ch stalls, the result register holds its beat; the
//   next request is still taken and waits in the update step until the
//   register is drained.
// ----------------------------------------------------------------------------
module reentrant_lock_table_unit #(
  parameter int NUM_SLOTS  = 8,
  parameter int KEY_BITS   = 32,
  parameter int OWNER_BITS = 8,
  parameter int DEPTH_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  rlt_in_if.sink      in_ch,
  rlt_out_if.source   out_ch
);
  import rlt_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // Sequencer
  rlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Slot table and decision logic
  rlt_dpath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .KEY_BITS   (KEY_BITS),
    .OWNER_BITS (OWNER_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_cmd          (in_ch.cmd),
    .in_resource_key (in_ch.resource_key),
    .in_requester_id (in_ch.requester_id),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_slot_index  (out_ch.slot_index),
    .out_depth_after (out_ch.depth_after)
  );

endmodule

>>> src/rlt_checker.sv
// ----------------------------------------------------------------------------
// rlt_checker: port-level checks for the reentrant lock table
// Watches both channels of the top level; bound in below.
// ----------------------------------------------------------------------------
module rlt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [2:0]  out_slot_index,
  input logic [15:0] out_depth_after
);
  import rlt_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_slot_index) && $stable(out_depth_after))
    else $error("result beat changed while stalled");

  // One request in flight: no second request right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // Empty-key, full and unmatched results carry no depth
  a_no_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_IGNORED || out_status == ST_FULL
      || out_status == ST_UNMATCHED) |-> out_depth_after == '0)
    else $error("depth reported for a result without a lock");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind reentrant_lock_table_unit rlt_checker u_rlt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_slot_index  (out_ch.slot_index),
  .out_depth_after (out_ch.depth_after)
);

>>> dv/tb_reentrant_lock_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reentrant_lock_table_unit: self-checking bench for the lock table
// Drives lock requests over the valid/ready request channel and checks every
// result beat against a behavioral copy of the slot table. A directed table
// comes first, then random traffic mostly on the claimed keys, with random gaps and
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb_reentrant_lock_table_unit;
  import rlt_pkg::*;

  localparam int SLOTS       = 8;
  localparam int RAND_ITEMS  = 925;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_CYCLES  = 1_500_000;
  localparam int DRAIN_WAIT  = 10;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic [KEY_W-1:0]   SAT_KEY   = 32'h1234_5678;
  localparam logic [OWNER_W-1:0] SAT_OWNER = 8'hC3;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   slot;
    logic [DEPTH_W-1:0] depth;
  } lock_result_t;

  typedef struct packed {
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [OWNER_W-1:0] who;
    logic               typed;   // use exp as written instead of the predictor
    lock_result_t       exp;
  } dir_row_t;

  localparam lock_result_t NO_RESULT = '{ST_GRANTED, 3'd0, 16'd0};
  localparam int DIR_ROWS = 23;

  // Directed requests: empty key, ownership, nesting, fill-up, table full
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{CMD_ACQUIRE, 32'h0000_0000, 8'hFF, 1'b1, '{ST_IGNORED,   3'd0, 16'd0}},
    '{CMD_RELEASE, 32'h0000_0000, 8'h00, 1'b1, '{ST_IGNORED,   3'd0, 16'd0}},
    '{CMD_RELEASE, 32'hFFFF_FFFF, 8'h00, 1'b1, '{ST_UNMATCHED, 3'd0, 16'd0}},
    '{CMD_ACQUIRE, 32'hFFFF_FFFF, 8'h00, 1'b1, '{ST_GRANTED,   3'd0, 16'd1}},
    '{CMD_ACQUIRE, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_RESULT},
    '{CMD_ACQUIRE, 32'hFFFF_FFFF, 8'hFF, 1'b0, NO_RESULT},
    '{CMD_RELEASE, 32'hFFFF_FFFF, 8'hFF, 1'b0, NO_RESULT},
    '{CMD_RELEASE, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_RESULT},
    '{CMD_RELEASE, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_RESULT},
    '{CMD_RELEASE, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_RESULT},
    '{CMD_ACQUIRE, 32'hFFFF_FFFF, 8'hFF, 1'b0, NO_RESULT},
    '{CMD_ACQUIRE, 32'h0000_0001, 8'h5A, 1'b0, NO_RESULT},
    '{CMD_RELEASE, 32'h0000_0001, 8'hA5, 1'b0, NO_RESULT},
    '{CMD_RELEASE, 32'h0000_0001, 8'h5A, 1'b0, NO_RESULT},
    '{CMD_RELEASE, 32'h0000_0001, 8'h5A, 1'b0, NO_RESULT},
    '{CMD_ACQUIRE, 32'h8000_0000, 8'h01, 1'b0, NO_RESULT},
    '{CMD_ACQUIRE, 32'h5555_5555, 8'h80, 1'b0, NO_RESULT},
    '{CMD_ACQUIRE, 32'hAAAA_AAAA, 8'h55, 1'b0, NO_RESULT},
    '{CMD_ACQUIRE, 32'h0000_FFFF, 8'hAA, 1'b0, NO_RESULT},
    '{CMD_ACQUIRE, 32'hFFFF_0000, 8'h7F, 1'b0, NO_RESULT},
    '{CMD_ACQUIRE, SAT_KEY,       SAT_OWNER, 1'b0, NO_RESULT},
    '{CMD_ACQUIRE, 32'h0000_0007, 8'h33, 1'b1, '{ST_FULL,      3'd0, 16'd0}},
    '{CMD_RELEASE, 32'h0000_0007, 8'h33, 1'b1, '{ST_UNMATCHED, 3'd0, 16'd0}}
  };

  logic clk;
  logic rst_n;

  rlt_in_if  in_ch ();
  rlt_out_if out_ch ();

  reentrant_lock_table_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the slot table
  logic               tbl_valid [SLOTS];
  logic [KEY_W-1:0]   tbl_key   [SLOTS];
  logic [OWNER_W-1:0] tbl_owner [SLOTS];
  logic [DEPTH_W-1:0] tbl_depth [SLOTS];

  lock_result_t pending_results [$];
  int           fail_count   = 0;
  bit           no_idle      = 1'b0;
  bit           hold_pending = 1'b0;

  function automatic lock_result_t make_result(status_t st, int slot, logic [DEPTH_W-1:0] d);
    lock_result_t res;
    res.status = st;
    res.slot   = (slot < 0) ? '0 : slot[IDX_W-1:0];
    res.depth  = d;
    return res;
  endfunction

  // Apply one request to the shadow table and return its result beat
  function automatic lock_result_t apply_request(logic op, logic [KEY_W-1:0] key,
                                                 logic [OWNER_W-1:0] who);
    int hit;
    int i;
    hit = -1;
    if (key == '0) return make_result(ST_IGNORED, -1, '0);
    for (i = 0; i < SLOTS; i++)
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;

    if (op == CMD_ACQUIRE) begin
      // claim the lowest free slot on a miss
      for (i = 0; i < SLOTS; i++) begin
        if (hit < 0 && !tbl_valid[i]) begin
          hit          = i;
          tbl_valid[i] = 1'b1;
          tbl_key[i]   = key;
          tbl_owner[i] = '0;
          tbl_depth[i] = '0;
        end
      end
      if (hit < 0) return make_result(ST_FULL, -1, '0);
      if (tbl_depth[hit] != '0 && tbl_owner[hit] != who)
        return make_result(ST_BUSY, hit, tbl_depth[hit]);
      if (tbl_depth[hit] == DEPTH_MAX)
        return make_result(ST_OVERFLOW, hit, DEPTH_MAX);
      if (tbl_depth[hit] == '0) tbl_owner[hit] = who;
      tbl_depth[hit] = tbl_depth[hit] + 1'b1;
      return make_result(ST_GRANTED, hit, tbl_depth[hit]);
    end

    if (hit < 0 || tbl_depth[hit] == '0) return make_result(ST_UNMATCHED, hit, '0);
    if (tbl_owner[hit] != who) return make_result(ST_NOT_OWNER, hit, tbl_depth[hit]);
    tbl_depth[hit] = tbl_depth[hit] - 1'b1;
    return make_result(ST_RELEASED, hit, tbl_depth[hit]);
  endfunction

  // Offer one request beat after a random gap; record its expected result
  task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [OWNER_W-1:0] who,
                              logic typed, lock_result_t exp);
    int           gap;
    lock_result_t got;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= op;
    in_ch.resource_key <= key;
    in_ch.requester_id <= who;
    do @(posedge clk); while (!in_ch.ready);
    got = apply_request(op, key, who);
    pending_results.push_back(typed ? exp : got);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycles,
           pending_results.size());
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    lock_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d slot %0d depth %0d",
               out_ch.status, out_ch.slot_index, out_ch.depth_after);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.slot_index !== want.slot) begin
          $error("slot_index mismatch: expected %0d actual %0d", want.slot,
                 out_ch.slot_index);
          fail_count++;
        end
        if (out_ch.depth_after !== want.depth) begin
          $error("depth_after mismatch: expected %0d actual %0d", want.depth,
                 out_ch.depth_after);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin : request_source
    int                 n_sent;
    int                 pick;
    int                 slot;
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [OWNER_W-1:0] who;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_ACQUIRE;
    in_ch.resource_key = '0;
    in_ch.requester_id = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_owner[i] = '0;
      tbl_depth[i] = '0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++)
      send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].who,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp);

    // random traffic, mostly on claimed keys with a small set of requesters
    n_sent = 0;
    while (n_sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, SLOTS - 1);
      if (pick < 5)
        key = '0;
      else if (pick < 15 || !tbl_valid[slot])
        key = $urandom;
      else
        key = tbl_key[slot];
      pick = $urandom_range(0, 99);
      if (pick < 55)
        who = tbl_owner[slot];
      else if (pick < 85)
        who = 8'h10 + 8'($urandom_range(0, 3));
      else
        who = 8'($urandom_range(0, 255));
      op = ($urandom_range(0, 1) == 0) ? CMD_ACQUIRE : CMD_RELEASE;
      no_idle = (n_sent % 128) >= 96;
      if (n_sent == 200) hold_pending = 1'b1;
      send_request(op, key, who, 1'b0, NO_RESULT);
      n_sent++;
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
